[hw/rtl/lbf_pkg.sv]
// Shared types, register codes and helpers of the LED brightness fade controller.
package lbf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_IN_DUR = 3'd0,
    CFG_DIM_DUR     = 3'd1,
    CFG_WAKE_DUR    = 3'd2,
    CFG_IDLE_LEVEL  = 3'd3,
    CFG_NORM_LEVEL  = 3'd4,
    CFG_IDLE_THRESH = 3'd5,
    CFG_CEILING     = 3'd6
  } cfg_idx_e;

  // Mode codes as they appear on the result beat.
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_FADE_IN = 3'd0;
  localparam mode_t MODE_NORMAL  = 3'd1;
  localparam mode_t MODE_DIMMING = 3'd2;
  localparam mode_t MODE_DIMMED  = 3'd3;
  localparam mode_t MODE_WAKING  = 3'd4;

  localparam logic [15:0] RstFadeInDur  = 16'd1000;
  localparam logic [15:0] RstDimDur     = 16'd2000;
  localparam logic [15:0] RstWakeDur    = 16'd300;
  localparam logic [7:0]  RstIdleLevel  = 8'd40;
  localparam logic [7:0]  RstNormLevel  = 8'd200;
  localparam logic [31:0] RstIdleThresh = 32'd60000;
  localparam logic [7:0]  RstCeiling    = 8'd255;

  typedef struct packed {
    logic [15:0] fade_in_dur;
    logic [15:0] dim_dur;
    logic [15:0] wake_dur;
    logic [7:0]  idle_level;
    logic [7:0]  normal_level;
    logic [31:0] idle_threshold;
    logic [7:0]  level_ceiling;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        pressed;
  } item_t;

  typedef struct packed {
    logic [7:0] brightness;
    mode_t      mode;
    logic       level_updated;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
    logic        neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] quot;
  } div_rsp_t;

  function automatic logic [7:0] clamp_level(input logic signed [33:0] v,
                                             input logic [7:0] ceil);
    logic [7:0] r;
    if (v > $signed({26'd0, ceil})) begin
      r = ceil;
    end else if (v < 34'sd0) begin
      r = 8'd0;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/lbf_div.sv]
// Shared restoring divider: one quotient bit per cycle, sign applied at the end.
module lbf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbf_pkg::div_req_t req_i,
  output lbf_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [lbf_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [15:0]                 rem_q, rem_d;
  logic [31:0]                 dvd_q, dvd_d;
  logic [15:0]                 dvs_q, dvs_d;
  logic                        neg_q, neg_d;
  logic [16:0]                 trial;
  logic                        ge;
  logic [16:0]                 diff;

  assign trial = {rem_q, dvd_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so 16 bits hold it.
      rem_d = ge ? diff[15:0] : trial[15:0];
      dvd_d = {dvd_q[30:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lbf_pkg::DivCntW'(lbf_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

[hw/rtl/lbf_core.sv]
// Sequencer and mode state of the fade controller; all divisions go to the shared divider.
module lbf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbf_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  lbf_pkg::item_t    item_i,
  output logic              item_ready_o,
  output logic              res_valid_o,
  input  logic              res_ack_i,
  output lbf_pkg::result_t  res_o,
  output lbf_pkg::div_req_t div_req_o,
  input  lbf_pkg::div_rsp_t div_rsp_i
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DISPATCH  = 9'b000000010,
    ST_RS_DIV    = 9'b000000100,
    ST_RS_WAIT   = 9'b000001000,
    ST_RS_FIN    = 9'b000010000,
    ST_REF_CHECK = 9'b000100000,
    ST_REF_WAIT  = 9'b001000000,
    ST_KEY_FIN   = 9'b010000000,
    ST_OUT       = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    RET_DISPATCH = 2'd0,
    RET_REFRESH  = 2'd1,
    RET_KEY      = 2'd2
  } ret_e;

  state_e               state_q, state_d;
  logic                 kind_q, kind_d;
  logic [31:0]          now_q, now_d;
  logic                 pressed_q, pressed_d;
  logic                 pending_q, pending_d;
  lbf_pkg::mode_t       mode_q, mode_d;
  logic [7:0]           goal_q, goal_d;
  logic [31:0]          end_q, end_d;
  logic signed [16:0]   slope_q, slope_d;
  logic [31:0]          press_q, press_d;
  logic                 held_q, held_d;
  logic [7:0]           level_q, level_d;
  logic                 upd_q, upd_d;

  // Arguments of the ramp start sub-sequence.
  logic [31:0]          rs_now_q, rs_now_d;
  logic [15:0]          rs_dur_q, rs_dur_d;
  logic signed [8:0]    rs_exp_q, rs_exp_d;
  logic [7:0]           rs_to_q, rs_to_d;
  lbf_pkg::mode_t       rs_mode_q, rs_mode_d;
  ret_e                 ret_q, ret_d;
  logic signed [16:0]   new_slope_q, new_slope_d;

  logic                 inactive;
  logic                 running;
  logic                 late;
  logic signed [8:0]    actual;
  logic signed [25:0]   prod;
  logic [31:0]          remaining;
  logic [31:0]          rem_mag;
  logic [16:0]          slope_mag;
  logic [8:0]           exp_mag;
  logic signed [33:0]   ramp_value;

  function automatic lbf_pkg::mode_t finished_mode(input lbf_pkg::mode_t m);
    lbf_pkg::mode_t r;
    case (m)
      lbf_pkg::MODE_FADE_IN: r = lbf_pkg::MODE_NORMAL;
      lbf_pkg::MODE_DIMMING: r = lbf_pkg::MODE_DIMMED;
      lbf_pkg::MODE_WAKING:  r = lbf_pkg::MODE_NORMAL;
      default:               r = m;
    endcase
    return r;
  endfunction

  assign inactive  = !held_q && ((now_q - press_q) > cfg_i.idle_threshold);
  assign running   = (mode_q == lbf_pkg::MODE_FADE_IN) || (mode_q == lbf_pkg::MODE_DIMMING) ||
                     (mode_q == lbf_pkg::MODE_WAKING);
  assign late      = now_q > end_q;
  assign actual    = $signed({1'b0, rs_to_q}) - $signed({1'b0, level_q});
  assign prod      = actual * new_slope_q;
  assign remaining = end_q - now_q;
  assign rem_mag   = remaining[31] ? (~remaining + 32'd1) : remaining;
  assign slope_mag = slope_q[16] ? 17'(-slope_q) : 17'(slope_q);
  assign exp_mag   = rs_exp_q[8] ? 9'(-rs_exp_q) : 9'(rs_exp_q);
  assign ramp_value = $signed({26'd0, goal_q}) - 34'(div_rsp_i.quot);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    now_d       = now_q;
    pressed_d   = pressed_q;
    pending_d   = pending_q;
    mode_d      = mode_q;
    goal_d      = goal_q;
    end_d       = end_q;
    slope_d     = slope_q;
    press_d     = press_q;
    held_d      = held_q;
    level_d     = level_q;
    upd_d       = upd_q;
    rs_now_d    = rs_now_q;
    rs_dur_d    = rs_dur_q;
    rs_exp_d    = rs_exp_q;
    rs_to_d     = rs_to_q;
    rs_mode_d   = rs_mode_q;
    ret_d       = ret_q;
    new_slope_d = new_slope_q;
    div_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          kind_d    = item_i.kind;
          now_d     = item_i.now_ms;
          pressed_d = item_i.pressed;
          upd_d     = 1'b0;
          if (pending_q) begin
            // First beat after reset: fade in from zero as if at time zero.
            pending_d = 1'b0;
            level_d   = 8'd0;
            rs_now_d  = 32'd0;
            rs_dur_d  = cfg_i.fade_in_dur;
            rs_exp_d  = $signed({1'b0, cfg_i.normal_level});
            rs_to_d   = cfg_i.normal_level;
            rs_mode_d = lbf_pkg::MODE_FADE_IN;
            ret_d     = RET_DISPATCH;
            state_d   = ST_RS_DIV;
          end else begin
            state_d = ST_DISPATCH;
          end
        end
      end
      ST_DISPATCH: begin
        rs_now_d = now_q;
        if (!kind_q) begin
          if ((mode_q == lbf_pkg::MODE_NORMAL) && inactive) begin
            rs_dur_d  = cfg_i.dim_dur;
            rs_exp_d  = $signed({1'b0, cfg_i.idle_level}) - $signed({1'b0, cfg_i.normal_level});
            rs_to_d   = cfg_i.idle_level;
            rs_mode_d = lbf_pkg::MODE_DIMMING;
            ret_d     = RET_REFRESH;
            state_d   = ST_RS_DIV;
          end else begin
            state_d = ST_REF_CHECK;
          end
        end else begin
          if (inactive) begin
            rs_dur_d  = cfg_i.wake_dur;
            rs_exp_d  = $signed({1'b0, cfg_i.normal_level}) - $signed({1'b0, cfg_i.idle_level});
            rs_to_d   = cfg_i.normal_level;
            rs_mode_d = lbf_pkg::MODE_WAKING;
            ret_d     = RET_KEY;
            state_d   = ST_RS_DIV;
          end else begin
            state_d = ST_KEY_FIN;
          end
        end
      end
      ST_RS_DIV: begin
        if (rs_exp_q == 9'sd0) begin
          new_slope_d = 17'sd0;
          state_d     = ST_RS_FIN;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {16'd0, rs_dur_q};
          div_req_o.divisor  = {8'd0, exp_mag[7:0]};
          div_req_o.neg      = rs_exp_q[8];
          state_d            = ST_RS_WAIT;
        end
      end
      ST_RS_WAIT: begin
        if (div_rsp_i.done) begin
          new_slope_d = div_rsp_i.quot[16:0];
          state_d     = ST_RS_FIN;
        end
      end
      ST_RS_FIN: begin
        goal_d = rs_to_q;
        if (new_slope_q == 17'sd0) begin
          // The ramp is over before it starts: jump to the goal.
          slope_d = 17'sd0;
          end_d   = rs_now_q;
          mode_d  = finished_mode(rs_mode_q);
          if (rs_mode_q == lbf_pkg::MODE_FADE_IN) begin
            press_d = rs_now_q;
          end
          level_d = lbf_pkg::clamp_level($signed({26'd0, rs_to_q}), cfg_i.level_ceiling);
          upd_d   = 1'b1;
        end else begin
          slope_d = new_slope_q;
          mode_d  = rs_mode_q;
          end_d   = rs_now_q + {{6{prod[25]}}, prod};
        end
        case (ret_q)
          RET_DISPATCH: state_d = ST_DISPATCH;
          RET_REFRESH:  state_d = ST_REF_CHECK;
          RET_KEY:      state_d = ST_KEY_FIN;
          default:      state_d = ST_OUT;
        endcase
      end
      ST_REF_CHECK: begin
        if (late && !running) begin
          state_d = ST_OUT;
        end else begin
          // A ramp that ran past its end is marked done, yet this beat still
          // takes its level from the ramp.
          if (late) begin
            mode_d = finished_mode(mode_q);
            if (mode_q == lbf_pkg::MODE_FADE_IN) begin
              press_d = now_q;
            end
          end
          if (running && (slope_q != 17'sd0)) begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = rem_mag;
            div_req_o.divisor  = slope_mag[15:0];
            div_req_o.neg      = remaining[31] ^ slope_q[16];
            state_d            = ST_REF_WAIT;
          end else begin
            level_d = lbf_pkg::clamp_level($signed({26'd0, goal_q}), cfg_i.level_ceiling);
            upd_d   = 1'b1;
            state_d = ST_OUT;
          end
        end
      end
      ST_REF_WAIT: begin
        if (div_rsp_i.done) begin
          level_d = lbf_pkg::clamp_level(ramp_value, cfg_i.level_ceiling);
          upd_d   = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_KEY_FIN: begin
        press_d = now_q;
        held_d  = pressed_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b1;
      mode_q    <= lbf_pkg::MODE_FADE_IN;
      goal_q    <= 8'd0;
      end_q     <= 32'd0;
      slope_q   <= 17'sd0;
      press_q   <= 32'd0;
      held_q    <= 1'b0;
      level_q   <= 8'd0;
      upd_q     <= 1'b0;
      ret_q     <= RET_DISPATCH;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      mode_q    <= mode_d;
      goal_q    <= goal_d;
      end_q     <= end_d;
      slope_q   <= slope_d;
      press_q   <= press_d;
      held_q    <= held_d;
      level_q   <= level_d;
      upd_q     <= upd_d;
      ret_q     <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    now_q       <= now_d;
    pressed_q   <= pressed_d;
    rs_now_q    <= rs_now_d;
    rs_dur_q    <= rs_dur_d;
    rs_exp_q    <= rs_exp_d;
    rs_to_q     <= rs_to_d;
    rs_mode_q   <= rs_mode_d;
    new_slope_q <= new_slope_d;
  end

  assign item_ready_o            = (state_q == ST_IDLE);
  assign res_valid_o             = (state_q == ST_OUT);
  assign res_o.brightness        = level_q;
  assign res_o.mode              = mode_q;
  assign res_o.level_updated     = upd_q;

endmodule

[hw/rtl/led_brightness_fade_controller.sv]
// Top level of the LED brightness fade controller: registers, output stage, core and divider.
//
// Takes one beat at a time and answers each with exactly one result beat. A
// key beat that starts no ramp needs no division; a refresh beat along a
// running ramp waits on the 32-step restoring divider that all slope and
// level divisions share. The very first beat after reset also works out the
// fade-in slope, and a refresh that begins the dimming ramp works out its
// slope first, so the worst beat needs three divisions.
// The result sits in an output register, so a new beat is taken while the
// previous result still waits on the master side.
module led_brightness_fade_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input beats.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // now_ms[31:0], pressed[32], zero pad
  input  logic [0:0]                     s_axis_tuser,  // kind[0]
  // Result beats.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // brightness[7:0], mode[10:8],
                                                        // level_updated[11], zero pad
  // Register writes.
  input  logic                           cfg_we_i,
  input  logic [lbf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lbf_pkg::CfgDataW-1:0]   cfg_data_i
);

  lbf_pkg::cfg_t     cfg_q, cfg_d;
  lbf_pkg::item_t    item;
  lbf_pkg::result_t  res;
  lbf_pkg::result_t  out_q, out_d;
  lbf_pkg::div_req_t div_req;
  lbf_pkg::div_rsp_t div_rsp;
  logic              out_valid_q, out_valid_d;
  logic              res_valid;
  logic              res_ack;
  logic              item_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lbf_pkg::cfg_idx_e'(cfg_idx_i))
        lbf_pkg::CFG_FADE_IN_DUR: cfg_d.fade_in_dur    = cfg_data_i[15:0];
        lbf_pkg::CFG_DIM_DUR:     cfg_d.dim_dur        = cfg_data_i[15:0];
        lbf_pkg::CFG_WAKE_DUR:    cfg_d.wake_dur       = cfg_data_i[15:0];
        lbf_pkg::CFG_IDLE_LEVEL:  cfg_d.idle_level     = cfg_data_i[7:0];
        lbf_pkg::CFG_NORM_LEVEL:  cfg_d.normal_level   = cfg_data_i[7:0];
        lbf_pkg::CFG_IDLE_THRESH: cfg_d.idle_threshold = cfg_data_i[31:0];
        lbf_pkg::CFG_CEILING:     cfg_d.level_ceiling  = cfg_data_i[7:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_in_dur    <= lbf_pkg::RstFadeInDur;
      cfg_q.dim_dur        <= lbf_pkg::RstDimDur;
      cfg_q.wake_dur       <= lbf_pkg::RstWakeDur;
      cfg_q.idle_level     <= lbf_pkg::RstIdleLevel;
      cfg_q.normal_level   <= lbf_pkg::RstNormLevel;
      cfg_q.idle_threshold <= lbf_pkg::RstIdleThresh;
      cfg_q.level_ceiling  <= lbf_pkg::RstCeiling;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.kind    = s_axis_tuser[0];
  assign item.now_ms  = s_axis_tdata[31:0];
  assign item.pressed = s_axis_tdata[32];

  lbf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (res_valid),
    .res_ack_i    (res_ack),
    .res_o        (res),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  lbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = item_ready;

  // The output register frees itself in the same cycle its beat is taken.
  assign res_ack = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ack) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.level_updated, out_q.mode, out_q.brightness};

endmodule

[hw/rtl/lbf_checker.sv]
// Port-level checks on the fade controller, bound to its top level.
module lbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // One beat at a time: the block is busy in the cycle after it takes one.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after a beat");

  // A waiting result beat stays put until it is taken.
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // Only the five defined modes are ever reported.
  a_mode_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:8] <= 3'd4))
    else $error("result carries an undefined mode");

  // The block only goes busy when it has taken a beat.
  a_no_result_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("block went busy without taking a beat");

endmodule

bind led_brightness_fade_controller lbf_checker u_lbf_checker (.*);

[bench/led_brightness_fade_controller_test.sv]
// Self-checking testbench of the LED brightness fade controller with its own brightness tracker.
module led_brightness_fade_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbf_pkg::*;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseBeats  = 190;
  localparam int unsigned ScriptRows  = 29;

  typedef enum bit {STEP_BEAT, STEP_WRITE} step_e;

  typedef struct packed {
    step_e       step;
    cfg_idx_e    idx;
    logic [31:0] value;     // time of a beat, or the register value of a write
    logic        kind;
    logic        pressed;
    bit          typed;
    logic [7:0]  exp_level;
    mode_t       exp_mode;
    logic        exp_upd;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // now_ms[31:0], pressed[32], zero pad
  logic [0:0]  s_axis_tuser;   // kind[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // brightness[7:0], mode[10:8], level_updated[11], zero pad
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  led_brightness_fade_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Tracker state, mirroring the block from reset onwards.
  cfg_t        regs = '{fade_in_dur: RstFadeInDur, dim_dur: RstDimDur,
                        wake_dur: RstWakeDur, idle_level: RstIdleLevel,
                        normal_level: RstNormLevel, idle_threshold: RstIdleThresh,
                        level_ceiling: RstCeiling};
  mode_t       md         = MODE_FADE_IN;
  bit          starting   = 1'b1;
  logic [7:0]  goal       = 8'd0;
  logic [31:0] ramp_end   = 32'd0;
  int          slope      = 0;
  logic [31:0] last_press = 32'd0;
  bit          held       = 1'b0;
  logic [7:0]  level      = 8'd0;

  result_t     pending_levels[$];
  int unsigned mismatches = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned quiet      = 0;

  // Beats in order; a write waits for the block to drain first.
  row_t script [ScriptRows] = '{
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd0,         KIND_TICK, 1'b0, 1'b1, 8'd0,   MODE_FADE_IN, 1'b1},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd500,       KIND_TICK, 1'b0, 1'b1, 8'd100, MODE_FADE_IN, 1'b1},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd1000,      KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd1001,      KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd2000,      KIND_TICK, 1'b0, 1'b1, 8'd200, MODE_NORMAL,  1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd3000,      KIND_KEY,  1'b1, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd100000,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd100001,    KIND_KEY,  1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd160002,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd161000,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170000,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170001,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170002,    KIND_KEY,  1'b1, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170102,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170203,    KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd170300,    KIND_KEY,  1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_WRITE, CFG_WAKE_DUR,    32'd0,         KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd300000,    KIND_KEY,  1'b0, 1'b1, 8'd200, MODE_NORMAL,  1'b1},
    '{STEP_WRITE, CFG_CEILING,     32'd0,         KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd300001,    KIND_TICK, 1'b0, 1'b1, 8'd200, MODE_NORMAL,  1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd400000,    KIND_KEY,  1'b0, 1'b1, 8'd0,   MODE_NORMAL,  1'b1},
    '{STEP_WRITE, CFG_CEILING,     32'd255,       KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_WRITE, CFG_IDLE_THRESH, 32'hFFFF_FFFF, KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'hFFFF_FFFF, KIND_TICK, 1'b1, 1'b1, 8'd0,   MODE_NORMAL,  1'b0},
    '{STEP_WRITE, CFG_IDLE_THRESH, 32'd0,         KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd0,         KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd5,         KIND_KEY,  1'b1, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'd6,         KIND_KEY,  1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0},
    '{STEP_BEAT,  CFG_FADE_IN_DUR, 32'h8000_0000, KIND_TICK, 1'b0, 1'b0, 8'd0,   MODE_FADE_IN, 1'b0}
  };

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic bit idle_now(input logic [31:0] now);
    return !held && ((now - last_press) > regs.idle_threshold);
  endfunction

  function automatic logic [7:0] clip(input longint v);
    if (v > longint'(regs.level_ceiling)) return regs.level_ceiling;
    if (v < 0) return 8'd0;
    return v[7:0];
  endfunction

  function automatic void end_ramp(input logic [31:0] now);
    case (md)
      MODE_FADE_IN: begin
        last_press = now;
        md = MODE_NORMAL;
      end
      MODE_DIMMING: md = MODE_DIMMED;
      MODE_WAKING:  md = MODE_NORMAL;
      default: ;
    endcase
  endfunction

  // Returns 1 when the ramp is over at once and the level jumps to the goal.
  function automatic bit begin_ramp(input logic [31:0] now, input logic [15:0] dur,
                                    input logic [7:0] src_lvl, input logic [7:0] dst_lvl,
                                    input mode_t next_mode);
    int span;
    int left;
    int step;
    span = int'(dst_lvl) - int'(src_lvl);
    left = int'(dst_lvl) - int'(level);
    step = (span != 0) ? int'(dur) / span : 0;
    goal = dst_lvl;
    md = next_mode;
    if (step == 0) begin
      slope = 0;
      ramp_end = now;
      end_ramp(now);
      level = clip(longint'(dst_lvl));
      return 1'b1;
    end
    slope = step;
    ramp_end = now + 32'(left * step);
    return 1'b0;
  endfunction

  function automatic bit refresh_level(input logic [31:0] now);
    bit                 ramping;
    logic signed [31:0] ahead;
    longint             value;
    if (md == MODE_NORMAL && idle_now(now)) begin
      void'(begin_ramp(now, regs.dim_dur, regs.normal_level, regs.idle_level, MODE_DIMMING));
    end
    ramping = (md == MODE_FADE_IN || md == MODE_DIMMING || md == MODE_WAKING);
    if (now > ramp_end) begin
      if (!ramping) return 1'b0;
      // The ramp is closed, yet this tick still follows the ramp line.
      end_ramp(now);
    end
    if (ramping && slope != 0) begin
      ahead = ramp_end - now;
      value = longint'(goal) - longint'(ahead) / longint'(slope);
    end else begin
      value = longint'(goal);
    end
    level = clip(value);
    return 1'b1;
  endfunction

  function automatic result_t track_brightness(input logic kind, input logic [31:0] now,
                                               input logic pressed);
    result_t r;
    bit      upd;
    upd = 1'b0;
    if (starting) begin
      starting = 1'b0;
      level = 8'd0;
      if (begin_ramp(32'd0, regs.fade_in_dur, 8'd0, regs.normal_level, MODE_FADE_IN)) begin
        upd = 1'b1;
      end
    end
    if (kind == KIND_TICK) begin
      if (refresh_level(now)) upd = 1'b1;
    end else begin
      if (idle_now(now)) begin
        if (begin_ramp(now, regs.wake_dur, regs.idle_level, regs.normal_level, MODE_WAKING)) begin
          upd = 1'b1;
        end
      end
      last_press = now;
      held = pressed;
    end
    r.brightness = level;
    r.mode = md;
    r.level_updated = upd;
    return r;
  endfunction

  task automatic send_beat(input logic kind, input logic [31:0] now, input logic pressed,
                           input bit typed, input result_t fixed);
    result_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'd0, pressed, now};
    s_axis_tuser = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = track_brightness(kind, now, pressed);
    pending_levels.push_back(typed ? fixed : predicted);
    @(negedge clk_i);
  endtask

  // Leaves the block with nothing in flight.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_FADE_IN_DUR: regs.fade_in_dur = val[15:0];
      CFG_DIM_DUR:     regs.dim_dur = val[15:0];
      CFG_WAKE_DUR:    regs.wake_dur = val[15:0];
      CFG_IDLE_LEVEL:  regs.idle_level = val[7:0];
      CFG_NORM_LEVEL:  regs.normal_level = val[7:0];
      CFG_IDLE_THRESH: regs.idle_threshold = val;
      CFG_CEILING:     regs.level_ceiling = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_setting(input int unsigned phase);
    logic [15:0] fade;
    logic [15:0] dim;
    logic [15:0] wake;
    logic [7:0]  low_lvl;
    logic [7:0]  norm_lvl;
    logic [31:0] thresh;
    logic [7:0]  ceil_lvl;
    fade = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    dim = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    wake = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1000)) : 16'($urandom);
    low_lvl = 8'($urandom);
    norm_lvl = 8'($urandom);
    thresh = ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, 5000)) : $urandom;
    ceil_lvl = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom);
    case (phase)
      0: begin
        fade = '0;
        dim = '0;
        wake = '0;
        low_lvl = '0;
        norm_lvl = '0;
        thresh = '0;
        ceil_lvl = '0;
      end
      1: begin
        fade = '1;
        dim = '1;
        wake = '1;
        low_lvl = '1;
        norm_lvl = '1;
        thresh = '1;
        ceil_lvl = '1;
      end
      // Equal levels leave the dimming and waking ramps with no distance to cover.
      2: low_lvl = norm_lvl;
      default: ;
    endcase
    write_reg(CFG_FADE_IN_DUR, 32'(fade));
    write_reg(CFG_DIM_DUR, 32'(dim));
    write_reg(CFG_WAKE_DUR, 32'(wake));
    write_reg(CFG_IDLE_LEVEL, 32'(low_lvl));
    write_reg(CFG_NORM_LEVEL, 32'(norm_lvl));
    write_reg(CFG_IDLE_THRESH, thresh);
    write_reg(CFG_CEILING, 32'(ceil_lvl));
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t     want;
    logic [7:0]  got_level;
    mode_t       got_mode;
    logic        got_upd;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_level = m_axis_tdata[7:0];
      got_mode = m_axis_tdata[10:8];
      got_upd = m_axis_tdata[11];
      if (pending_levels.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        if (got_level !== want.brightness) begin
          $error("brightness: expected %0d, actual %0d", want.brightness, got_level);
          mismatches++;
        end
        if (got_mode !== want.mode) begin
          $error("mode: expected %0d, actual %0d", want.mode, got_mode);
          mismatches++;
        end
        if (got_upd !== want.level_updated) begin
          $error("level_updated: expected %0d, actual %0d", want.level_updated, got_upd);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] clock_ms;
    logic [31:0] now;
    logic        kind;
    logic        pressed;
    bit          key_down;
    int unsigned roll;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    key_down = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].step == STEP_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_beat(script[i].kind, script[i].value, script[i].pressed, script[i].typed,
                  '{brightness: script[i].exp_level, mode: script[i].exp_mode,
                    level_updated: script[i].exp_upd});
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      settle();
      load_setting(p);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      // Every other phase starts just short of the millisecond counter wrapping.
      clock_ms = (p % 2 != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                              : 32'($urandom_range(0, 1000));
      for (int unsigned n = 0; n < PhaseBeats; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          kind = 1'($urandom_range(0, 1));
          now = $urandom;
          pressed = 1'($urandom_range(0, 1));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 85) begin
            clock_ms += $urandom_range(0, 400);
          end else if (roll < 97) begin
            clock_ms += $urandom_range(1000, 20000);
          end else begin
            clock_ms += $urandom;
          end
          now = clock_ms;
          kind = ($urandom_range(0, 99) < 25) ? KIND_KEY : KIND_TICK;
          if (kind == KIND_KEY) begin
            pressed = ($urandom_range(0, 99) < 80) ? !key_down : 1'($urandom_range(0, 1));
            key_down = pressed;
          end else begin
            pressed = 1'($urandom_range(0, 1));
          end
        end
        send_beat(kind, now, pressed, 1'b0, '0);
      end
    end

    settle();
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
